// ===== rtl/u8ks_pkg.sv =====
package u8ks_pkg;

   // code point width: four-byte forms carry 3 + 6 + 6 + 6 bits
   localparam int CP_W = 21;

   // key actions as they appear on the result channel
   typedef enum logic [2:0] {
      ACT_CHAR    = 3'd0,
      ACT_PREFIX  = 3'd1,
      ACT_HEX     = 3'd2,
      ACT_CONFIRM = 3'd3,
      ACT_RETURN  = 3'd4,
      ACT_TAB     = 3'd5
   } action_type;

   // pause classes after a key
   localparam logic [1:0] DLY_CHAR = 2'd0;
   localparam logic [1:0] DLY_LINE = 2'd1;
   localparam logic [1:0] DLY_STEP = 2'd2;

   // what a queued code point turns into
   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_RETURN  = 2'd1,
      KIND_TAB     = 2'd2,
      KIND_UNICODE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE    = 2'd0,
      BK_DIGIT   = 2'd1,
      BK_CONFIRM = 2'd2
   } back_state_type;

   localparam logic [CP_W-1:0] CP_TAB      = CP_W'(9);
   localparam logic [CP_W-1:0] CP_LF       = CP_W'(10);
   localparam logic [CP_W-1:0] CP_SPACE    = CP_W'(32);
   localparam logic [CP_W-1:0] CP_TILDE    = CP_W'(126);

   typedef struct packed {
      kind_type        kind;
      logic [CP_W-1:0] code_point;
      logic [2:0]      top_nib;
      logic            last;
   } entry_type;

   // true when a code point gives at least one key action
   function automatic logic gives_keys(input logic [CP_W-1:0] cp);
      gives_keys = (cp == CP_TAB) || (cp == CP_LF) || (cp >= CP_SPACE);
   endfunction

   // announced length of a sequence from its first byte, 0 for a stray byte
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      if (b[7] == 1'b0) begin
         lead_length = 3'd1;
      end else if ((b & 8'hE0) == 8'hC0) begin
         lead_length = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         lead_length = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         lead_length = 3'd4;
      end else begin
         lead_length = 3'd0;
      end
   endfunction

   function automatic logic [3:0] nibble_at(input logic [CP_W-1:0] cp, input logic [2:0] idx);
      case (idx)
         3'd0:    nibble_at = cp[3:0];
         3'd1:    nibble_at = cp[7:4];
         3'd2:    nibble_at = cp[11:8];
         3'd3:    nibble_at = cp[15:12];
         3'd4:    nibble_at = cp[19:16];
         3'd5:    nibble_at = {3'b000, cp[20]};
         default: nibble_at = 4'h0;
      endcase
   endfunction

   // index of the highest nonzero nibble, 0 when only the lowest is left
   function automatic logic [2:0] top_nibble(input logic [CP_W-1:0] cp);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 1; i < 6; i++) begin
         if (nibble_at(cp, 3'(i)) != 4'h0) begin
            idx = 3'(i);
         end
      end
      top_nibble = idx;
   endfunction

   // lowercase hex digit
   function automatic logic [6:0] hex_char(input logic [3:0] d);
      if (d < 4'd10) begin
         hex_char = 7'h30 + {3'b000, d};
      end else begin
         hex_char = 7'h61 + {3'b000, d} - 7'd10;
      end
   endfunction

   function automatic kind_type kind_of(input logic [CP_W-1:0] cp);
      if (cp == CP_LF) begin
         kind_of = KIND_RETURN;
      end else if (cp == CP_TAB) begin
         kind_of = KIND_TAB;
      end else if (cp > CP_TILDE) begin
         kind_of = KIND_UNICODE;
      end else begin
         kind_of = KIND_CHAR;
      end
   endfunction

endpackage

// ===== rtl/u8ks_front.sv =====
module u8ks_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   output logic                  byte_ready,
   input  logic [7:0]            text_byte,
   input  logic                  end_of_text,
   output logic                  push_valid,
   input  logic                  push_ready,
   output u8ks_pkg::entry_type   push_data
);

   localparam int NCAND = 7;

   logic [7:0]                  held_ff [3];
   logic [7:0]                  held_in [3];
   logic [1:0]                  held_cnt_ff, held_cnt_in;
   logic [2:0]                  seq_len_ff, seq_len_in;
   logic [u8ks_pkg::CP_W-1:0]   cand_ff [NCAND];
   logic [u8ks_pkg::CP_W-1:0]   cand_in [NCAND];
   logic [NCAND-1:0]            cand_vld_ff, cand_vld_in;

   logic                        accept;
   logic [2:0]                  sel;
   logic [NCAND-1:0]            rest;
   logic [u8ks_pkg::CP_W-1:0]   sel_cp;

   assign byte_ready = (cand_vld_ff == '0);
   assign accept     = byte_valid && byte_ready;

   // oldest pending code point goes out first
   always_comb begin
      sel = 3'd0;
      for (int i = NCAND - 1; i >= 0; i--) begin
         if (cand_vld_ff[i]) begin
            sel = 3'(i);
         end
      end
   end

   assign rest   = cand_vld_ff & ~(NCAND'(1) << sel);
   assign sel_cp = cand_ff[sel];

   assign push_valid           = (cand_vld_ff != '0);
   assign push_data.kind       = u8ks_pkg::kind_of(sel_cp);
   assign push_data.code_point = sel_cp;
   assign push_data.top_nib    = u8ks_pkg::top_nibble(sel_cp);
   assign push_data.last       = (rest == '0);

   always_comb begin
      logic                        brk;
      logic [2:0]                  lead_len;
      logic [u8ks_pkg::CP_W-1:0]   imm_cp;
      logic                        imm_v;
      logic [u8ks_pkg::CP_W-1:0]   seq_cp;

      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;
      cand_in     = cand_ff;
      cand_vld_in = cand_vld_ff;
      brk         = 1'b0;
      lead_len    = 3'd0;
      imm_cp      = '0;
      imm_v       = 1'b0;
      seq_cp      = '0;

      if (push_valid && push_ready) begin
         cand_vld_in = rest;
      end

      if (accept) begin
         brk      = (held_cnt_ff != 2'd0) && (text_byte[7:6] != 2'b10);
         lead_len = u8ks_pkg::lead_length(text_byte);

         // broken sequence: held bytes go out one by one
         for (int i = 0; i < 3; i++) begin
            cand_in[i]     = u8ks_pkg::CP_W'(held_ff[i]);
            cand_vld_in[i] = brk && (2'(i) < held_cnt_ff) &&
                             u8ks_pkg::gives_keys(u8ks_pkg::CP_W'(held_ff[i]));
         end

         case (seq_len_ff)
            3'd2:    seq_cp = {10'd0, held_ff[0][4:0], text_byte[5:0]};
            3'd3:    seq_cp = {5'd0, held_ff[0][3:0], held_ff[1][5:0], text_byte[5:0]};
            default: seq_cp = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0],
                               text_byte[5:0]};
         endcase

         if ((held_cnt_ff == 2'd0) || brk) begin
            if (lead_len <= 3'd1) begin
               imm_cp      = u8ks_pkg::CP_W'(text_byte);
               imm_v       = 1'b1;
               held_cnt_in = 2'd0;
               seq_len_in  = 3'd0;
            end else begin
               held_in[0]  = text_byte;
               held_cnt_in = 2'd1;
               seq_len_in  = lead_len;
            end
         end else if (({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff) begin
            imm_cp      = seq_cp;
            imm_v       = 1'b1;
            held_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
         end else begin
            held_in[held_cnt_ff] = text_byte;
            held_cnt_in          = held_cnt_ff + 2'd1;
         end

         cand_in[3]     = imm_cp;
         cand_vld_in[3] = imm_v && u8ks_pkg::gives_keys(imm_cp);

         // end of text flushes whatever is still held
         for (int i = 0; i < 3; i++) begin
            cand_in[4 + i]     = u8ks_pkg::CP_W'(held_in[i]);
            cand_vld_in[4 + i] = end_of_text && (2'(i) < held_cnt_in) &&
                                 u8ks_pkg::gives_keys(u8ks_pkg::CP_W'(held_in[i]));
         end

         if (end_of_text) begin
            held_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
         cand_vld_ff <= '0;
      end else begin
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
         cand_vld_ff <= cand_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      cand_ff <= cand_in;
   end

endmodule

// ===== rtl/u8ks_queue.sv =====
module u8ks_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  u8ks_pkg::entry_type   push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output u8ks_pkg::entry_type   pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8ks_pkg::entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/u8ks_back.sv =====
module u8ks_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  u8ks_pkg::entry_type   pop_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output u8ks_pkg::action_type  out_action,
   output logic [6:0]            out_char,
   output logic [1:0]            out_delay,
   output logic                  out_last
);

   u8ks_pkg::back_state_type    state_ff, state_in;
   logic [u8ks_pkg::CP_W-1:0]   cur_cp_ff, cur_cp_in;
   logic                        cur_last_ff, cur_last_in;
   logic [2:0]                  nib_ff, nib_in;

   logic                        out_valid_ff, out_valid_in;
   u8ks_pkg::action_type        out_action_ff, out_action_in;
   logic [6:0]                  out_char_ff, out_char_in;
   logic [1:0]                  out_delay_ff, out_delay_in;
   logic                        out_last_ff, out_last_in;

   logic                        adv;
   logic                        emit;

   assign adv = !out_valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         u8ks_pkg::BK_IDLE: begin
            if (adv && pop_valid && (pop_data.kind == u8ks_pkg::KIND_UNICODE)) begin
               state_in = u8ks_pkg::BK_DIGIT;
            end
         end
         u8ks_pkg::BK_DIGIT: begin
            if (adv && (nib_ff == 3'd0)) begin
               state_in = u8ks_pkg::BK_CONFIRM;
            end
         end
         u8ks_pkg::BK_CONFIRM: begin
            if (adv) begin
               state_in = u8ks_pkg::BK_IDLE;
            end
         end
         default: state_in = u8ks_pkg::BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop_ready     = 1'b0;
      emit          = 1'b0;
      cur_cp_in     = cur_cp_ff;
      cur_last_in   = cur_last_ff;
      nib_in        = nib_ff;
      out_action_in = out_action_ff;
      out_char_in   = out_char_ff;
      out_delay_in  = out_delay_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         u8ks_pkg::BK_IDLE: begin
            pop_ready = adv;
            if (adv && pop_valid) begin
               emit         = 1'b1;
               out_char_in  = 7'd0;
               out_delay_in = u8ks_pkg::DLY_CHAR;
               out_last_in  = pop_data.last;
               case (pop_data.kind)
                  u8ks_pkg::KIND_CHAR: begin
                     out_action_in = u8ks_pkg::ACT_CHAR;
                     out_char_in   = pop_data.code_point[6:0];
                  end
                  u8ks_pkg::KIND_RETURN: begin
                     out_action_in = u8ks_pkg::ACT_RETURN;
                     out_delay_in  = u8ks_pkg::DLY_LINE;
                  end
                  u8ks_pkg::KIND_TAB: begin
                     out_action_in = u8ks_pkg::ACT_TAB;
                  end
                  default: begin
                     out_action_in = u8ks_pkg::ACT_PREFIX;
                     out_delay_in  = u8ks_pkg::DLY_STEP;
                     out_last_in   = 1'b0;
                     cur_cp_in     = pop_data.code_point;
                     cur_last_in   = pop_data.last;
                     nib_in        = pop_data.top_nib;
                  end
               endcase
            end
         end
         u8ks_pkg::BK_DIGIT: begin
            if (adv) begin
               emit          = 1'b1;
               out_action_in = u8ks_pkg::ACT_HEX;
               out_char_in   = u8ks_pkg::hex_char(u8ks_pkg::nibble_at(cur_cp_ff, nib_ff));
               out_delay_in  = u8ks_pkg::DLY_STEP;
               out_last_in   = 1'b0;
               if (nib_ff != 3'd0) begin
                  nib_in = nib_ff - 3'd1;
               end
            end
         end
         u8ks_pkg::BK_CONFIRM: begin
            if (adv) begin
               emit          = 1'b1;
               out_action_in = u8ks_pkg::ACT_CONFIRM;
               out_char_in   = 7'd0;
               out_delay_in  = u8ks_pkg::DLY_CHAR;
               out_last_in   = cur_last_ff;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   assign out_valid_in = emit || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u8ks_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_cp_ff     <= cur_cp_in;
      cur_last_ff   <= cur_last_in;
      nib_ff        <= nib_in;
      out_action_ff <= out_action_in;
      out_char_ff   <= out_char_in;
      out_delay_ff  <= out_delay_in;
      out_last_ff   <= out_last_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_action = out_action_ff;
   assign out_char   = out_char_ff;
   assign out_delay  = out_delay_ff;
   assign out_last   = out_last_ff;

`ifndef SYNTHESIS
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u8ks_pkg::BK_DIGIT) |-> (nib_ff <= 3'd5))
      else $error("digit index out of range");

   a_no_last_mid_chord: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ((out_action_ff == u8ks_pkg::ACT_PREFIX) ||
                        (out_action_ff == u8ks_pkg::ACT_HEX))) |-> !out_last_ff)
      else $error("run closed inside a unicode entry");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> (state_ff == u8ks_pkg::BK_IDLE))
      else $error("queue popped while expanding");

   a_prefix_then_digits: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_action_ff == u8ks_pkg::ACT_PREFIX)) |->
      (state_ff == u8ks_pkg::BK_DIGIT))
      else $error("prefix not followed by digits");
`endif

endmodule

// ===== rtl/utf8_text_to_keystroke_sequencer_core.sv =====
// first key action of a byte reaches rsp_ through the front candidate registers, queue and back end output register
// throughput: one key action per cycle from the back end while rsp_tready holds, up to sixteen per byte;
//   the front takes a new byte once all code points of the previous one are queued,
//   so the back end expansion sets the sustained rate
// reset: synchronous, active high; clears decoder state, queue and output register
module utf8_text_to_keystroke_sequencer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] text_byte
   input  logic        req_tlast,    // end_of_text
   // key action channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [2:0] action, [9:3] key_char, [11:10] delay_class, zeros
   output logic        rsp_tlast     // last_of_run
);

   // front end: utf-8 decoder, turns each byte transfer into up to four code points
   // (broken sequence, the byte itself, end-of-text flush), dropping silent controls
   u8ks_pkg::entry_type   push_data;
   logic                  push_valid;
   logic                  push_ready;

   // queue output toward the key expander
   u8ks_pkg::entry_type   pop_data;
   logic                  pop_valid;
   logic                  pop_ready;

   // back end result fields
   u8ks_pkg::action_type  out_action;
   logic [6:0]            out_char;
   logic [1:0]            out_delay;

   u8ks_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // short queue lets the decoder run ahead of the key expansion
   u8ks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back end: one key action per cycle while rsp_tready holds; unicode points become prefix, hex digits
   // from the top nonzero nibble down, then confirm
   u8ks_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_action (out_action),
      .out_char   (out_char),
      .out_delay  (out_delay),
      .out_last   (rsp_tlast)
   );

   // pack the result fields, lowest field first, padded to two bytes
   assign rsp_tdata = {4'b0000, out_delay, out_char, out_action};

endmodule
